// ===== rtl/core/met_pkg.sv =====
// Shared constants and types for the Mandelbrot escape-time colorer.
`timescale 1ns / 1ps
`default_nettype none
package met_pkg;

  localparam int FRAC_BITS = 28;
  localparam int ITER_BITS = 16;
  localparam int IN_W      = 32;
  localparam int WORK_W    = 40;
  localparam int BOUND_W   = 3;
  // A non-escaped z part never exceeds bound << FRAC_BITS, so this covers any multiplier operand
  localparam int MAG_W     = BOUND_W + FRAC_BITS;
  localparam int PROD_W    = 2 * MAG_W;
  localparam int SUM_W     = WORK_W + 2;
  localparam int CHAN_W    = 8;
  localparam int NUM_W     = CHAN_W + ITER_BITS;
  localparam int DIV_CNT_W = $clog2(NUM_W + 1);
  localparam int COLOR_W   = 32;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 3;

  localparam logic [BOUND_W-1:0]   BOUND_RESET  = BOUND_W'(2);
  localparam logic [ITER_BITS-1:0] NITER_RESET  = ITER_BITS'(5000);
  localparam logic [COLOR_W-1:0]   INSIDE_COLOR = 32'hff00_0000;
  localparam logic [CHAN_W-1:0]    CHAN_MAX     = 8'hff;

  localparam logic signed [WORK_W-1:0] WORK_MAX = {1'b0, {(WORK_W-1){1'b1}}};
  localparam logic signed [WORK_W-1:0] WORK_MIN = {1'b1, {(WORK_W-1){1'b0}}};

  // Register indexes on the configuration port
  localparam logic REG_BOUND = 1'b0;
  localparam logic REG_NITER = 1'b1;

  // One classified point waiting for the iteration engine
  typedef struct packed {
    logic signed [WORK_W-1:0] c_re;
    logic signed [WORK_W-1:0] c_im;
    logic [MAG_W-1:0]         lim;
    logic [ITER_BITS-1:0]     n;
  } met_job_t;

endpackage
`default_nettype wire

// ===== rtl/core/met_if.sv =====
// Valid/ready channel interfaces for points in and colored results out.
`timescale 1ns / 1ps
`default_nettype none
interface met_in_if;
  logic                            valid;
  logic                            ready;
  logic signed [met_pkg::IN_W-1:0] c_real;
  logic signed [met_pkg::IN_W-1:0] c_imag;
  modport source (output valid, output c_real, output c_imag, input ready);
  modport sink (input valid, input c_real, input c_imag, output ready);
endinterface

interface met_out_if;
  logic                             valid;
  logic                             ready;
  logic [met_pkg::ITER_BITS-1:0]    iteration_count;
  logic                             escaped;
  logic [met_pkg::COLOR_W-1:0]      color_word;
  modport source (output valid, output iteration_count, output escaped, output color_word,
                  input ready);
  modport sink (input valid, input iteration_count, input escaped, input color_word,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/core/met_front.sv =====
// Front end: accepts points, converts c to working format and snapshots the limits.
`timescale 1ns / 1ps
`default_nettype none
module met_front (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  met_in_if.sink                               in_if,
  input  wire logic [met_pkg::BOUND_W-1:0]     bound_i,
  input  wire logic [met_pkg::ITER_BITS-1:0]   niter_i,
  output logic                                 job_valid_o,
  input  wire logic                            job_ready_i,
  output met_pkg::met_job_t                    job_o
);

  logic              hold_q;
  met_pkg::met_job_t job_q, job_d;

  assign in_if.ready = !hold_q || job_ready_i;
  assign job_valid_o = hold_q;
  assign job_o       = job_q;

  // Sign-extend c (input and working formats share the fraction width), scale the bound
  always_comb begin
    job_d.c_re = met_pkg::WORK_W'(in_if.c_real);
    job_d.c_im = met_pkg::WORK_W'(in_if.c_imag);
    job_d.lim  = {bound_i, {met_pkg::FRAC_BITS{1'b0}}};
    job_d.n    = niter_i;
  end

  // Hold one word until the queue takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
      job_q  <= '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        hold_q <= 1'b1;
        job_q  <= job_d;
      end else if (job_ready_i) begin
        hold_q <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/met_queue.sv =====
// Two-entry queue between the front end and the iteration engine.
`timescale 1ns / 1ps
`default_nettype none
module met_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_valid_i,
  output logic                   push_ready_o,
  input  wire met_pkg::met_job_t push_data_i,
  output logic                   pop_valid_o,
  input  wire logic              pop_ready_i,
  output met_pkg::met_job_t      pop_data_o
);

  met_pkg::met_job_t entry_q [2];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        cnt_q;
  logic              do_push, do_pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 2'd1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 2'd1;
    end
  end

  // Store the pushed word
  always_ff @(posedge clk_i) begin
    if (do_push) entry_q[wr_ptr_q] <= push_data_i;
  end

endmodule
`default_nettype wire

// ===== rtl/core/met_div.sv =====
// Restoring divider, one quotient bit per cycle, for the color gradient.
`timescale 1ns / 1ps
`default_nettype none
module met_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [met_pkg::NUM_W-1:0]     num_i,
  input  wire logic [met_pkg::ITER_BITS-1:0] den_i,
  output logic                               done_o,
  output logic [met_pkg::CHAN_W-1:0]         quo_o,
  output logic                               rem_nz_o
);

  logic [met_pkg::NUM_W-1:0]     num_q;
  logic [met_pkg::ITER_BITS-1:0] den_q;
  logic [met_pkg::ITER_BITS-1:0] rem_q;
  logic [met_pkg::DIV_CNT_W-1:0] cnt_q;
  logic                          busy_q, done_q;
  logic [met_pkg::ITER_BITS:0]   trial;
  logic                          fits;

  // Quotient is below 2^CHAN_W since the dividend is 255 times a value under the divisor
  assign quo_o    = num_q[met_pkg::CHAN_W-1:0];
  assign rem_nz_o = (rem_q != '0);
  assign done_o   = done_q;

  assign trial = {rem_q, num_q[met_pkg::NUM_W-1]};
  assign fits  = (trial >= {1'b0, den_q});

  // Shift in one dividend bit and subtract when it fits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q  <= '0;
      den_q  <= '0;
      rem_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == met_pkg::DIV_CNT_W'(1));
      if (start_i) begin
        num_q  <= num_i;
        den_q  <= den_i;
        rem_q  <= '0;
        cnt_q  <= met_pkg::DIV_CNT_W'(met_pkg::NUM_W);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        num_q <= {num_q[met_pkg::NUM_W-2:0], fits};
        rem_q <= fits ? met_pkg::ITER_BITS'(trial - {1'b0, den_q})
                      : trial[met_pkg::ITER_BITS-1:0];
        cnt_q <= cnt_q - met_pkg::DIV_CNT_W'(1);
        if (cnt_q == met_pkg::DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/met_back.sv =====
// Back end: iterates z = z*z + c, tests the escape box and forms the colored result.
`timescale 1ns / 1ps
`default_nettype none
module met_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              job_valid_i,
  output logic                   job_ready_o,
  input  wire met_pkg::met_job_t job_i,
  met_out_if.source              out_if
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_DIV,
    ST_HOLD
  } state_e;

  state_e                          state_q;
  met_pkg::met_job_t               job_q;
  logic signed [met_pkg::WORK_W-1:0] zr_q, zi_q;
  logic [met_pkg::ITER_BITS-1:0]   step_q, last_q;
  logic [met_pkg::PROD_W-1:0]      prr_q, pii_q, pri_q;
  logic                            neg_q;

  // Pending result, then the output register
  logic [met_pkg::ITER_BITS-1:0]   res_cnt_q;
  logic                            res_esc_q;
  logic [met_pkg::COLOR_W-1:0]     res_col_q;
  logic                            ov_q;
  logic [met_pkg::ITER_BITS-1:0]   o_cnt_q;
  logic                            o_esc_q;
  logic [met_pkg::COLOR_W-1:0]     o_col_q;
  logic                            load_out;

  logic                            div_start_q;
  logic [met_pkg::NUM_W-1:0]       div_num_q;
  logic                            div_done;
  logic [met_pkg::CHAN_W-1:0]      div_quo;
  logic                            div_rem_nz;

  logic [met_pkg::WORK_W-1:0]      mag_re, mag_im;
  logic [met_pkg::WORK_W-1:0]      mag_nr, mag_ni;
  logic signed [met_pkg::SUM_W-1:0] rr_s, ii_s, ri_s, sum_re, sum_im;
  logic signed [met_pkg::WORK_W-1:0] zr_d, zi_d;
  logic                            esc;
  logic [met_pkg::CHAN_W:0]        ceil_g;
  logic [met_pkg::CHAN_W:0]        red_w;

  function automatic logic [met_pkg::WORK_W-1:0] mag_of(logic signed [met_pkg::WORK_W-1:0] v);
    mag_of = v[met_pkg::WORK_W-1] ? met_pkg::WORK_W'(-v) : met_pkg::WORK_W'(v);
  endfunction

  function automatic logic signed [met_pkg::WORK_W-1:0] sat_w(
      logic signed [met_pkg::SUM_W-1:0] v);
    if (v > met_pkg::SUM_W'(met_pkg::WORK_MAX))      sat_w = met_pkg::WORK_MAX;
    else if (v < met_pkg::SUM_W'(met_pkg::WORK_MIN)) sat_w = met_pkg::WORK_MIN;
    else                                             sat_w = v[met_pkg::WORK_W-1:0];
  endfunction

  met_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start_q),
    .num_i    (div_num_q),
    .den_i    (job_q.n),
    .done_o   (div_done),
    .quo_o    (div_quo),
    .rem_nz_o (div_rem_nz)
  );

  assign job_ready_o     = (state_q == ST_IDLE);
  assign out_if.valid    = ov_q;
  assign out_if.iteration_count = o_cnt_q;
  assign out_if.escaped  = o_esc_q;
  assign out_if.color_word = o_col_q;

  // Load the output register when a result waits and the register is free
  assign load_out = (state_q == ST_HOLD) && (!ov_q || out_if.ready);

  // Magnitudes of the current z; operands fit MAG_W because z has not escaped yet
  assign mag_re = mag_of(zr_q);
  assign mag_im = mag_of(zi_q);

  // Truncate products toward zero, then form the new z parts
  always_comb begin
    rr_s   = $signed(met_pkg::SUM_W'(prr_q >> met_pkg::FRAC_BITS));
    ii_s   = $signed(met_pkg::SUM_W'(pii_q >> met_pkg::FRAC_BITS));
    ri_s   = $signed(met_pkg::SUM_W'(pri_q >> met_pkg::FRAC_BITS));
    if (neg_q) ri_s = -ri_s;
    sum_re = rr_s - ii_s + met_pkg::SUM_W'(job_q.c_re);
    sum_im = (ri_s <<< 1) + met_pkg::SUM_W'(job_q.c_im);
    zr_d   = sat_w(sum_re);
    zi_d   = sat_w(sum_im);
    mag_nr = mag_of(zr_d);
    mag_ni = mag_of(zi_d);
    esc    = (mag_nr > met_pkg::WORK_W'(job_q.lim)) ||
             (mag_ni > met_pkg::WORK_W'(job_q.lim));
  end

  // Gradient: green = floor, red = 255 - ceil
  assign ceil_g = {1'b0, div_quo} + (met_pkg::CHAN_W + 1)'(div_rem_nz);
  assign red_w  = {1'b0, met_pkg::CHAN_MAX} - ceil_g;

  // Sequence one point: multiply, add and test, repeat, then color
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      job_q       <= '0;
      zr_q        <= '0;
      zi_q        <= '0;
      step_q      <= '0;
      last_q      <= '0;
      prr_q       <= '0;
      pii_q       <= '0;
      pri_q       <= '0;
      neg_q       <= 1'b0;
      res_cnt_q   <= '0;
      res_esc_q   <= 1'b0;
      res_col_q   <= '0;
      ov_q        <= 1'b0;
      o_cnt_q     <= '0;
      o_esc_q     <= 1'b0;
      o_col_q     <= '0;
      div_start_q <= 1'b0;
      div_num_q   <= '0;
    end else begin
      div_start_q <= (state_q == ST_ADD) && esc;
      if (load_out) ov_q <= 1'b1;
      else if (out_if.ready) ov_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (job_valid_i) begin
            job_q  <= job_i;
            zr_q   <= '0;
            zi_q   <= '0;
            step_q <= '0;
            last_q <= job_i.n - met_pkg::ITER_BITS'(1);
            if (job_i.n == '0) begin
              // Zero limit: no step runs
              res_cnt_q <= '0;
              res_esc_q <= 1'b0;
              res_col_q <= met_pkg::INSIDE_COLOR;
              state_q   <= ST_HOLD;
            end else begin
              state_q <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          prr_q   <= mag_re[met_pkg::MAG_W-1:0] * mag_re[met_pkg::MAG_W-1:0];
          pii_q   <= mag_im[met_pkg::MAG_W-1:0] * mag_im[met_pkg::MAG_W-1:0];
          pri_q   <= mag_re[met_pkg::MAG_W-1:0] * mag_im[met_pkg::MAG_W-1:0];
          neg_q   <= zr_q[met_pkg::WORK_W-1] ^ zi_q[met_pkg::WORK_W-1];
          state_q <= ST_ADD;
        end
        ST_ADD: begin
          zr_q <= zr_d;
          zi_q <= zi_d;
          if (esc) begin
            res_cnt_q   <= step_q;
            res_esc_q   <= 1'b1;
            div_num_q   <= {step_q, {met_pkg::CHAN_W{1'b0}}} - met_pkg::NUM_W'(step_q);
            state_q     <= ST_DIV;
          end else if (step_q == last_q) begin
            res_cnt_q <= job_q.n;
            res_esc_q <= 1'b0;
            res_col_q <= met_pkg::INSIDE_COLOR;
            state_q   <= ST_HOLD;
          end else begin
            step_q  <= step_q + met_pkg::ITER_BITS'(1);
            state_q <= ST_MUL;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            res_col_q <= {{(met_pkg::COLOR_W - 3 * met_pkg::CHAN_W){1'b0}},
                          red_w[met_pkg::CHAN_W-1:0], div_quo, {met_pkg::CHAN_W{1'b0}}};
            state_q   <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          // Move the result into the output register once it is free
          if (load_out) begin
            o_cnt_q <= res_cnt_q;
            o_esc_q <= res_esc_q;
            o_col_q <= res_col_q;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/mandelbrot_escape_time_colorer_unit.sv =====
// Top level: configuration registers, front end, queue and iteration engine.
//
//   port       dir   word / use
//   in_if      sink  c_real, c_imag (signed Q4.28 point)
//   out_if     src   iteration_count, escaped, color_word
//   psel..     apb   0x0 escape_bound (3 b), 0x4 max_iterations (16 b)
//
// Each iteration in the engine is a multiply step, then an add and box-test step. A point
// that escapes goes through the gradient divide before its result reaches the output
// register; a point that stays inside gets the inside color without it. The front end and
// a two-entry queue keep taking points while the engine works. Reset is asynchronous,
// active low; it restores bound 2 and limit 5000. A stalled output holds its word; the
// engine waits with the next.
`timescale 1ns / 1ps
`default_nettype none
module mandelbrot_escape_time_colorer_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  met_in_if.sink                            in_if,
  met_out_if.source                         out_if,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [met_pkg::APB_AW-1:0]   paddr,
  input  wire logic [met_pkg::APB_DW-1:0]   pwdata,
  output logic [met_pkg::APB_DW-1:0]        prdata,
  output logic                              pready
);

  logic [met_pkg::BOUND_W-1:0]   bound_q;
  logic [met_pkg::ITER_BITS-1:0] niter_q;
  logic                          wr_en;
  logic                          reg_sel;

  logic              f_valid, f_ready;
  met_pkg::met_job_t f_job;
  logic              q_valid, q_ready;
  met_pkg::met_job_t q_job;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  // Write the configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bound_q <= met_pkg::BOUND_RESET;
      niter_q <= met_pkg::NITER_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        met_pkg::REG_BOUND: bound_q <= pwdata[met_pkg::BOUND_W-1:0];
        met_pkg::REG_NITER: niter_q <= pwdata[met_pkg::ITER_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_sel)
      met_pkg::REG_BOUND: prdata = met_pkg::APB_DW'(bound_q);
      met_pkg::REG_NITER: prdata = met_pkg::APB_DW'(niter_q);
      default:            prdata = '0;
    endcase
  end

  met_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_if),
    .bound_i     (bound_q),
    .niter_i     (niter_q),
    .job_valid_o (f_valid),
    .job_ready_i (f_ready),
    .job_o       (f_job)
  );

  met_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_job),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_job)
  );

  met_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_ready_o (q_ready),
    .job_i       (q_job),
    .out_if      (out_if)
  );

endmodule
`default_nettype wire
